// ===== rtl/bdl_pkg.sv =====
// shared types and constants for the button debounce and long-press block
`timescale 1ns / 1ps
`default_nettype none

package bdl_pkg;

    localparam int BTN_CNT    = 4;
    localparam int IDX_W      = 2;
    localparam int DBT_W      = 8;
    localparam int LPT_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DBT_W-1:0] DBT_RESET = 8'd25;
    localparam logic [LPT_W-1:0] LPT_RESET = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;

    // what one lane found in one tick
    typedef struct packed {
        logic evt;
        logic long_press;
    } t_lane_evt;

endpackage

`default_nettype wire

// ===== rtl/bdl_in_if.sv =====
// input channel: one timer tick carrying the button pin levels
`timescale 1ns / 1ps
`default_nettype none

interface bdl_in_if
    import bdl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BTN_CNT-1:0] pin_levels;

    modport source (output valid, output pin_levels, input ready);
    modport sink (input valid, input pin_levels, output ready);
endinterface

`default_nettype wire

// ===== rtl/bdl_out_if.sv =====
// output channel: one press or long-press event
`timescale 1ns / 1ps
`default_nettype none

interface bdl_out_if
    import bdl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] button_index;
    logic             long_press;
    logic             last;

    modport source (output valid, output button_index, output long_press, output last,
                    input ready);
    modport sink (input valid, input button_index, input long_press, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/bdl_lane.sv =====
// one button lane: edge arming, debounce countdown and hold counter
`timescale 1ns / 1ps
`default_nettype none

module bdl_lane
    import bdl_pkg::*;
#(
    parameter int HOLD_WIDTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_tick,
    input  wire logic             i_pin,
    input  wire logic [DBT_W-1:0] i_debounce_ticks,
    input  wire logic [LPT_W-1:0] i_long_press_ticks,
    output t_lane_evt             o_evt
);

    localparam int CMP_W = (HOLD_WIDTH > LPT_W) ? HOLD_WIDTH : LPT_W;
    localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = {HOLD_WIDTH{1'b1}};

    logic                  r_prev, n_prev;
    logic                  r_edge_sel, n_edge_sel;
    logic                  r_armed, n_armed;
    logic                  r_active, n_active;
    logic [DBT_W-1:0]      r_dcnt, n_dcnt;
    logic [HOLD_WIDTH-1:0] r_hold, n_hold;

    logic                  hold_inc_ok;
    logic [HOLD_WIDTH-1:0] hold_inc;
    logic                  expire;
    logic                  settled;
    logic                  edge_mid;
    logic                  armed_mid;
    logic                  hit;

    always_comb begin
        hold_inc_ok = (r_hold != HOLD_MAX);
        hold_inc    = hold_inc_ok ? HOLD_WIDTH'(r_hold + 1'b1) : r_hold;
        expire      = r_active && (r_dcnt <= DBT_W'(1));
        // level differs from the armed direction bit: a real press or release
        settled     = expire && (r_edge_sel != i_pin);
        edge_mid    = settled ? ~r_edge_sel : r_edge_sel;
        armed_mid   = r_armed | expire;
        hit         = armed_mid && (edge_mid ? (r_prev && !i_pin) : (!r_prev && i_pin));

        o_evt.evt        = settled && i_pin;
        o_evt.long_press = (CMP_W'(hold_inc) >= CMP_W'(i_long_press_ticks));

        n_prev     = i_pin;
        n_edge_sel = edge_mid;
        n_hold     = (settled && !i_pin) ? '0 : hold_inc;
        if (hit) begin
            n_armed  = 1'b0;
            n_active = 1'b1;
            n_dcnt   = (i_debounce_ticks == '0) ? DBT_W'(1) : i_debounce_ticks;
        end else begin
            n_armed  = armed_mid;
            n_active = r_active && !expire;
            if (expire) begin
                n_dcnt = '0;
            end else if (r_active) begin
                n_dcnt = r_dcnt - 1'b1;
            end else begin
                n_dcnt = r_dcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= 1'b1;
            r_edge_sel <= 1'b1;
            r_armed    <= 1'b1;
            r_active   <= 1'b0;
            r_dcnt     <= '0;
            r_hold     <= '0;
        end else if (i_tick) begin
            r_prev     <= n_prev;
            r_edge_sel <= n_edge_sel;
            r_armed    <= n_armed;
            r_active   <= n_active;
            r_dcnt     <= n_dcnt;
            r_hold     <= n_hold;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bdl_merge.sv =====
// merges lane events of a tick, drains one word per cycle if ready
`timescale 1ns / 1ps
`default_nettype none

module bdl_merge
    import bdl_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_lane_evt i_lane [BTN_CNT],
    bdl_out_if.source      o_out
);

    logic               r_bat_vld;
    logic [BTN_CNT-1:0] r_bat_mask;
    logic [BTN_CNT-1:0] r_bat_long;
    logic [BTN_CNT-1:0] r_pend, n_pend;
    logic [BTN_CNT-1:0] r_plong;

    logic [BTN_CNT-1:0] lane_mask;
    logic [BTN_CNT-1:0] lane_long;
    logic [BTN_CNT-1:0] low_bit;
    logic [BTN_CNT-1:0] rest;
    logic [IDX_W-1:0]   low_idx;
    logic               out_fire;
    logic               in_fire;
    logic               drain_free;

    always_comb begin
        for (int i = 0; i < BTN_CNT; i++) begin
            lane_mask[i] = i_lane[i].evt;
            lane_long[i] = i_lane[i].long_press;
        end
        low_bit = r_pend & BTN_CNT'(~r_pend + 1'b1);
        rest    = r_pend & ~low_bit;
        low_idx = '0;
        for (int i = BTN_CNT - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                low_idx = IDX_W'(i);
            end
        end
    end

    assign out_fire   = o_out.valid && o_out.ready;
    // drain holds nothing after this cycle
    assign drain_free = (r_pend == '0) || (out_fire && (rest == '0));
    assign o_in_ready = !r_bat_vld || drain_free;
    assign in_fire    = i_in_valid && o_in_ready;

    assign o_out.valid        = (r_pend != '0);
    assign o_out.button_index = low_idx;
    assign o_out.long_press   = |(r_plong & low_bit);
    assign o_out.last         = (rest == '0);

    always_comb begin
        if (drain_free) begin
            n_pend = r_bat_vld ? r_bat_mask : '0;
        end else if (out_fire) begin
            n_pend = rest;
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bat_vld <= 1'b0;
            r_pend    <= '0;
        end else begin
            r_pend <= n_pend;
            if (in_fire) begin
                r_bat_vld <= (lane_mask != '0);
            end else if (drain_free) begin
                r_bat_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_bat_mask <= lane_mask;
            r_bat_long <= lane_long;
        end
        if (drain_free) begin
            r_plong <= r_bat_long;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/button_debounce_longpress.sv =====
// top level: four-button debounce with long-press events
// the events of a tick pass the batch register, then the pending register of the drain
// throughput: a tick per cycle while no events are pending; a tick with events
//   holds the drain stage until its last event word leaves, one event word per cycle while o_out.ready is high
// a batch register in front of the drain takes the next tick while events wait
// reset: synchronous active low, all buttons released and armed for press
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_longpress
    import bdl_pkg::*;
#(
    parameter int HOLD_WIDTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bdl_in_if.sink                     i_in,
    bdl_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers; the user must write them only while idle, the block does not enforce it
    logic [DBT_W-1:0] r_debounce_ticks;
    logic [LPT_W-1:0] r_long_press_ticks;

    logic      w_in_ready;
    logic      w_tick;
    t_lane_evt w_lane [BTN_CNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= DBT_RESET;
            r_long_press_ticks <= LPT_RESET;
        end else if (i_cfg_we) begin
            // unknown register indexes fall through and are dropped
            if (i_cfg_idx == CFG_DEBOUNCE) begin
                r_debounce_ticks <= i_cfg_data[DBT_W-1:0];
            end
            if (i_cfg_idx == CFG_LONG_PRESS) begin
                r_long_press_ticks <= i_cfg_data[LPT_W-1:0];
            end
        end
    end

    assign i_in.ready = w_in_ready;
    // all lanes step together on each accepted tick
    assign w_tick     = i_in.valid && w_in_ready;

    // one lane per button, each with its own arming, debounce and hold state
    for (genvar g = 0; g < BTN_CNT; g++) begin : g_lane
        bdl_lane #(
            .HOLD_WIDTH (HOLD_WIDTH)
        ) u_lane (
            .i_clk              (i_clk),
            .i_rst_n            (i_rst_n),
            .i_tick             (w_tick),
            .i_pin              (i_in.pin_levels[g]),
            .i_debounce_ticks   (r_debounce_ticks),
            .i_long_press_ticks (r_long_press_ticks),
            .o_evt              (w_lane[g])
        );
    end

    // collects the release events of a tick and sends them lowest button first
    bdl_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_lane     (w_lane),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
